@@ hdl/s2x_pkg.sv @@
// Shared constants, codes and the result word type of the Scale2x palette upscaler.
// No dependencies; every other file in hdl/ imports this package.
package s2x_pkg;

    // Defaults for the top level parameters.
    localparam int S2X_LINE_PIXELS     = 256;
    localparam int S2X_MAX_SCALED_ROWS = 240;
    localparam int S2X_INDEX_BITS      = 15;

    // Port field widths.
    localparam int OP_W      = 2;
    localparam int PIXEL_W   = 15;
    localparam int COLOUR_W  = 16;
    localparam int COORD_W   = 9;
    localparam int WIDTH_W   = 10;
    localparam int HEIGHT_W  = 9;

    // Configuration port.
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = WIDTH_W;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;
    localparam logic [WIDTH_W-1:0]     SOURCE_WIDTH_RESET  = 10'd256;
    localparam logic [HEIGHT_W-1:0]    SOURCE_HEIGHT_RESET = 9'd240;

    // Passthrough line length limits.
    localparam logic [WIDTH_W-1:0] PASS_MAX_WIDTH = 10'd512;
    localparam logic [COORD_W-1:0] PASS_LAST_COL  = 9'd511;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PIXEL   = 2'd0;
    localparam logic [OP_W-1:0] OP_FLUSH   = 2'd1;
    localparam logic [OP_W-1:0] OP_PALETTE = 2'd2;

    // Result queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [COLOUR_W-1:0] top_left;
        logic [COLOUR_W-1:0] top_right;
        logic [COLOUR_W-1:0] bottom_left;
        logic [COLOUR_W-1:0] bottom_right;
        logic                block_valid;
        logic [COORD_W-1:0]  source_column;
        logic [COORD_W-1:0]  source_row;
        logic                frame_done;
    } s2x_result_t;

endpackage

@@ hdl/s2x_if.sv @@
// Valid/ready stream interfaces for the input items and the result words.
// Depends on s2x_pkg for the field widths.
interface s2x_in_if import s2x_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [PIXEL_W-1:0]  pixel;
    logic [PIXEL_W-1:0]  palette_index;
    logic [COLOUR_W-1:0] palette_value;

    modport source (output valid, output operation, output pixel, output palette_index,
                    output palette_value, input ready);
    modport sink (input valid, input operation, input pixel, input palette_index,
                  input palette_value, output ready);
endinterface

interface s2x_out_if import s2x_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [COLOUR_W-1:0] top_left;
    logic [COLOUR_W-1:0] top_right;
    logic [COLOUR_W-1:0] bottom_left;
    logic [COLOUR_W-1:0] bottom_right;
    logic                block_valid;
    logic [COORD_W-1:0]  source_column;
    logic [COORD_W-1:0]  source_row;
    logic                frame_done;

    modport source (output valid, output top_left, output top_right, output bottom_left,
                    output bottom_right, output block_valid, output source_column,
                    output source_row, output frame_done, input ready);
    modport sink (input valid, input top_left, input top_right, input bottom_left,
                  input bottom_right, input block_valid, input source_column,
                  input source_row, input frame_done, output ready);
endinterface

@@ hdl/scale2x_palette_upscaler.sv @@
// Top level of the Scale2x palette upscaler: counters, three-stage pipeline, result queue.
// Depends on s2x_pkg, s2x_if, s2x_lines and s2x_palette.

// The block takes one input word per clock and keeps that rate for as long as results
// are taken: each word reads the line banks in the cycle it is accepted, the palette in
// the next, and its result enters a four-word output queue in the one after. Input ready
// depends only on the space left in that queue once the words still in flight are
// counted, not on the state of the result side in the same cycle. A palette write is
// seen by the very next word. The palette and line buffers have no reset content and
// need no clearing pass; the block is ready straight out of reset.
module scale2x_palette_upscaler import s2x_pkg::*; #(
    parameter int LINE_PIXELS     = S2X_LINE_PIXELS,
    parameter int MAX_SCALED_ROWS = S2X_MAX_SCALED_ROWS,
    parameter int INDEX_BITS      = S2X_INDEX_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    s2x_in_if.sink                 items,
    s2x_out_if.source              results,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int X_W   = $clog2(LINE_PIXELS);
    localparam int COL_W = (X_W > COORD_W) ? X_W : COORD_W;

    // Configuration.
    logic [WIDTH_W-1:0]  width_reg,  width_next;
    logic [HEIGHT_W-1:0] height_reg, height_next;

    // Position counters and left neighbour.
    logic [COL_W-1:0]      col_reg, col_next;
    logic [COORD_W-1:0]    row_reg, row_next;
    logic [INDEX_BITS-1:0] left_reg;

    // Stage 0 decode.
    logic                  accept;
    logic                  scaled;
    logic [INDEX_BITS-1:0] pix_idx;
    logic [X_W-1:0]        x;
    logic                  at_end;
    logic [COORD_W-1:0]    last_col;
    logic [HEIGHT_W:0]     row_plus1;
    logic                  s0_res;
    logic                  s0_line;
    logic                  s0_flush;
    logic                  s0_blk;
    logic                  s0_done;
    logic [COORD_W-1:0]    s0_col;
    logic [COORD_W-1:0]    s0_row;

    // Stage 1: line data available.
    logic                  s1_res_reg;
    logic                  s1_line_reg;
    logic                  s1_flush_reg;
    logic                  s1_blk_reg;
    logic                  s1_done_reg;
    logic [X_W-1:0]        s1_x_reg;
    logic                  s1_at_end_reg;
    logic                  s1_row2_reg;
    logic [INDEX_BITS-1:0] s1_pix_reg;
    logic [COORD_W-1:0]    s1_col_reg;
    logic [COORD_W-1:0]    s1_row_reg;

    logic [INDEX_BITS-1:0] mid, right_pix, left_pix, upper_pix;
    logic [INDEX_BITS-1:0] a_pix, b_pix, c_pix, d_pix, p_pix;
    logic                  mix;

    // Stage 2: palette data available.
    logic                  s2_res_reg;
    logic                  s2_blk_reg;
    logic                  s2_done_reg;
    logic                  s2_tl_reg, s2_tr_reg, s2_bl_reg, s2_br_reg;
    logic [COORD_W-1:0]    s2_col_reg;
    logic [COORD_W-1:0]    s2_row_reg;
    logic [COLOUR_W-1:0]   pal_p, pal_a, pal_d;
    s2x_result_t           s2_word;

    // Result queue.
    s2x_result_t           fifo_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic [FIFO_CNT_W:0]   in_use;
    logic                  push, pop;
    s2x_result_t           head;

    // ---------------------------------------------------------------- configuration
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_SOURCE_WIDTH:  width_next  = cfg_data;
                REG_SOURCE_HEIGHT: height_next = cfg_data[HEIGHT_W-1:0];
                default:           width_next  = width_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------- stage 0
    assign accept  = items.valid && items.ready;
    assign pix_idx = INDEX_BITS'(items.pixel);
    assign scaled  = (int'(width_reg) == LINE_PIXELS) && (int'(height_reg) <= MAX_SCALED_ROWS);

    always_comb
    begin
        // A column beyond the line counts as the last column.
        x         = (int'(col_reg) < LINE_PIXELS) ? col_reg[X_W-1:0] : X_W'(LINE_PIXELS - 1);
        at_end    = (x == X_W'(LINE_PIXELS - 1));
        last_col  = ((width_reg == '0) || (width_reg > PASS_MAX_WIDTH)) ? PASS_LAST_COL
                    : COORD_W'(width_reg - WIDTH_W'(1));
        row_plus1 = {1'b0, row_reg} + (HEIGHT_W+1)'(1);

        col_next = col_reg;
        row_next = row_reg;
        s0_res   = 1'b0;
        s0_line  = 1'b0;
        s0_flush = 1'b0;
        s0_blk   = 1'b0;
        s0_done  = 1'b0;
        s0_col   = col_reg[COORD_W-1:0];
        s0_row   = row_reg;

        case (items.operation)
            OP_PIXEL:
            begin
                if (!scaled)
                begin
                    s0_res = 1'b1;
                    if (col_reg >= COL_W'(last_col))
                    begin
                        col_next = '0;
                        if ((height_reg == '0) || (row_plus1 >= {1'b0, height_reg}))
                        begin
                            s0_done  = 1'b1;
                            row_next = '0;
                        end
                        else
                        begin
                            row_next = row_reg + COORD_W'(1);
                        end
                    end
                    else
                    begin
                        col_next = col_reg + COL_W'(1);
                    end
                end
                else if ((height_reg != '0) && (row_reg < height_reg))
                begin
                    // The first row only fills the line buffer.
                    s0_line = 1'b1;
                    s0_res  = (row_reg != '0);
                    s0_blk  = 1'b1;
                    s0_col  = COORD_W'(x);
                    s0_row  = row_reg - COORD_W'(1);
                    if (at_end)
                    begin
                        col_next = '0;
                        row_next = row_reg + COORD_W'(1);
                    end
                    else
                    begin
                        col_next = COL_W'(x) + COL_W'(1);
                    end
                end
            end
            OP_FLUSH:
            begin
                if (scaled && (height_reg != '0) && (row_reg >= height_reg))
                begin
                    s0_res   = 1'b1;
                    s0_flush = 1'b1;
                    s0_blk   = 1'b1;
                    s0_done  = at_end;
                    s0_col   = COORD_W'(x);
                    s0_row   = row_reg - COORD_W'(1);
                    if (at_end)
                    begin
                        col_next = '0;
                        row_next = '0;
                    end
                    else
                    begin
                        col_next = COL_W'(x) + COL_W'(1);
                    end
                end
            end
            default:
            begin
                s0_res = 1'b0;
            end
        endcase
    end

    s2x_lines #(
        .LINE_PIXELS (LINE_PIXELS),
        .INDEX_BITS  (INDEX_BITS)
    ) u_lines (
        .clk         (clk),
        .rd_x        (x),
        .mid_wr_en   (accept && s0_line),
        .mid_wr_x    (x),
        .mid_wr_data (pix_idx),
        .up_wr_en    (s1_line_reg),
        .up_wr_x     (s1_x_reg),
        .up_wr_data  (mid),
        .mid_data    (mid),
        .right_data  (right_pix),
        .left_data   (left_pix),
        .upper_data  (upper_pix)
    );

    // ---------------------------------------------------------------- stage 1
    always_comb
    begin
        if (s1_x_reg == '0)
        begin
            b_pix = mid;
        end
        else
        begin
            b_pix = s1_flush_reg ? left_pix : left_reg;
        end
        c_pix = s1_at_end_reg ? mid : right_pix;
        a_pix = s1_row2_reg ? upper_pix : mid;
        d_pix = s1_flush_reg ? mid : s1_pix_reg;
        p_pix = s1_blk_reg ? mid : s1_pix_reg;
        mix   = (a_pix != d_pix) && (b_pix != c_pix);
    end

    s2x_palette #(
        .INDEX_BITS (INDEX_BITS)
    ) u_palette (
        .clk       (clk),
        .wr_en     (accept && (items.operation == OP_PALETTE)),
        .wr_addr   (INDEX_BITS'(items.palette_index)),
        .wr_data   (items.palette_value),
        .rd_p_addr (p_pix),
        .rd_a_addr (a_pix),
        .rd_d_addr (d_pix),
        .rd_p_data (pal_p),
        .rd_a_data (pal_a),
        .rd_d_data (pal_d)
    );

    // ---------------------------------------------------------------- stage 2
    always_comb
    begin
        s2_word.block_valid   = s2_blk_reg;
        s2_word.source_column = s2_col_reg;
        s2_word.source_row    = s2_row_reg;
        s2_word.frame_done    = s2_done_reg;
        if (s2_blk_reg)
        begin
            s2_word.top_left     = s2_tl_reg ? pal_a : pal_p;
            s2_word.top_right    = s2_tr_reg ? pal_a : pal_p;
            s2_word.bottom_left  = s2_bl_reg ? pal_d : pal_p;
            s2_word.bottom_right = s2_br_reg ? pal_d : pal_p;
        end
        else
        begin
            s2_word.top_left     = pal_p;
            s2_word.top_right    = '0;
            s2_word.bottom_left  = '0;
            s2_word.bottom_right = '0;
        end
    end

    // ---------------------------------------------------------------- result queue
    assign push   = s2_res_reg;
    assign pop    = results.valid && results.ready;
    assign in_use = {1'b0, count_reg} + (FIFO_CNT_W+1)'(s1_res_reg)
                    + (FIFO_CNT_W+1)'(s2_res_reg);
    assign head   = fifo_mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + FIFO_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - FIFO_CNT_W'(1);
        end
    end

    assign items.ready           = (in_use < (FIFO_CNT_W+1)'(FIFO_DEPTH));
    assign results.valid         = (count_reg != '0);
    assign results.top_left      = head.top_left;
    assign results.top_right     = head.top_right;
    assign results.bottom_left   = head.bottom_left;
    assign results.bottom_right  = head.bottom_right;
    assign results.block_valid   = head.block_valid;
    assign results.source_column = head.source_column;
    assign results.source_row    = head.source_row;
    assign results.frame_done    = head.frame_done;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[wr_ptr_reg] <= s2_word;
        end
    end

    // ---------------------------------------------------------------- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= SOURCE_WIDTH_RESET;
            height_reg  <= SOURCE_HEIGHT_RESET;
            col_reg     <= '0;
            row_reg     <= '0;
            left_reg    <= '0;
            s1_res_reg  <= 1'b0;
            s1_line_reg <= 1'b0;
            s2_res_reg  <= 1'b0;
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            count_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (s1_line_reg)
            begin
                left_reg <= mid;
            end
            s1_res_reg  <= accept && s0_res;
            s1_line_reg <= accept && s0_line;
            s2_res_reg  <= s1_res_reg;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // ---------------------------------------------------------------- pipeline payload
    always_ff @(posedge clk)
    begin
        s1_flush_reg  <= s0_flush;
        s1_blk_reg    <= s0_blk;
        s1_done_reg   <= s0_done;
        s1_x_reg      <= x;
        s1_at_end_reg <= at_end;
        s1_row2_reg   <= (row_reg > COORD_W'(1));
        s1_pix_reg    <= pix_idx;
        s1_col_reg    <= s0_col;
        s1_row_reg    <= s0_row;

        s2_blk_reg  <= s1_blk_reg;
        s2_done_reg <= s1_done_reg;
        s2_col_reg  <= s1_col_reg;
        s2_row_reg  <= s1_row_reg;
        s2_tl_reg   <= mix && (a_pix == b_pix);
        s2_tr_reg   <= mix && (a_pix == c_pix);
        s2_bl_reg   <= mix && (d_pix == b_pix);
        s2_br_reg   <= mix && (d_pix == c_pix);
    end

endmodule

@@ hdl/s2x_palette.sv @@
// Palette memory: two identical copies so that three colours can be looked up per cycle.
// Depends on s2x_pkg for the colour width.
module s2x_palette import s2x_pkg::*; #(
    parameter int INDEX_BITS = S2X_INDEX_BITS
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [INDEX_BITS-1:0] wr_addr,
    input  logic [COLOUR_W-1:0]   wr_data,
    input  logic [INDEX_BITS-1:0] rd_p_addr,
    input  logic [INDEX_BITS-1:0] rd_a_addr,
    input  logic [INDEX_BITS-1:0] rd_d_addr,
    output logic [COLOUR_W-1:0]   rd_p_data,
    output logic [COLOUR_W-1:0]   rd_a_data,
    output logic [COLOUR_W-1:0]   rd_d_data
);

    localparam int PAL_DEPTH = 1 << INDEX_BITS;

    logic [COLOUR_W-1:0] pal_main [PAL_DEPTH];
    logic [COLOUR_W-1:0] pal_copy [PAL_DEPTH];

    logic [COLOUR_W-1:0] rd_p_reg;
    logic [COLOUR_W-1:0] rd_a_reg;
    logic [COLOUR_W-1:0] rd_d_reg;

    // Both copies take every write, so they always hold the same colours.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pal_main[wr_addr] <= wr_data;
            pal_copy[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_p_reg <= pal_main[rd_p_addr];
        rd_a_reg <= pal_main[rd_a_addr];
        rd_d_reg <= pal_copy[rd_d_addr];
    end

    assign rd_p_data = rd_p_reg;
    assign rd_a_data = rd_a_reg;
    assign rd_d_data = rd_d_reg;

endmodule

@@ hdl/s2x_lines.sv @@
// Line buffers: the current line split into even and odd column banks, and the line above.
// Depends on s2x_pkg for the default parameter values.
module s2x_lines import s2x_pkg::*; #(
    parameter int LINE_PIXELS = S2X_LINE_PIXELS,
    parameter int INDEX_BITS  = S2X_INDEX_BITS
) (
    input  logic                         clk,
    input  logic [$clog2(LINE_PIXELS)-1:0] rd_x,
    input  logic                         mid_wr_en,
    input  logic [$clog2(LINE_PIXELS)-1:0] mid_wr_x,
    input  logic [INDEX_BITS-1:0]        mid_wr_data,
    input  logic                         up_wr_en,
    input  logic [$clog2(LINE_PIXELS)-1:0] up_wr_x,
    input  logic [INDEX_BITS-1:0]        up_wr_data,
    output logic [INDEX_BITS-1:0]        mid_data,
    output logic [INDEX_BITS-1:0]        right_data,
    output logic [INDEX_BITS-1:0]        left_data,
    output logic [INDEX_BITS-1:0]        upper_data
);

    import s2x_pkg::*;

    localparam int X_W    = $clog2(LINE_PIXELS);
    localparam int HALF   = (LINE_PIXELS + 1) / 2;
    localparam int BANK_W = X_W - 1;

    logic [INDEX_BITS-1:0] even_bank  [HALF];
    logic [INDEX_BITS-1:0] odd_bank   [HALF];
    logic [INDEX_BITS-1:0] upper_line [LINE_PIXELS];

    logic [X_W:0]        xp1;
    logic [X_W-1:0]      xm1;
    logic [BANK_W-1:0]   x_half;
    logic [BANK_W-1:0]   xp1_half;
    logic [BANK_W-1:0]   xm1_half;
    logic [BANK_W-1:0]   even_addr;
    logic [BANK_W-1:0]   odd_addr;

    logic                  par_reg;
    logic [INDEX_BITS-1:0] even_rd0_reg;
    logic [INDEX_BITS-1:0] even_rd1_reg;
    logic [INDEX_BITS-1:0] odd_rd0_reg;
    logic [INDEX_BITS-1:0] odd_rd1_reg;
    logic [INDEX_BITS-1:0] upper_rd_reg;

    // Columns x-1 and x+1 always sit in the bank opposite to column x, so each bank
    // needs at most two reads per cycle.
    always_comb
    begin
        xp1       = {1'b0, rd_x} + (X_W+1)'(1);
        xm1       = rd_x - X_W'(1);
        x_half    = rd_x[X_W-1:1];
        xp1_half  = xp1[X_W-1:1];
        xm1_half  = xm1[X_W-1:1];
        even_addr = rd_x[0] ? xp1_half : x_half;
        odd_addr  = rd_x[0] ? x_half : xp1_half;
    end

    always_ff @(posedge clk)
    begin
        par_reg      <= rd_x[0];
        even_rd0_reg <= even_bank[even_addr];
        even_rd1_reg <= even_bank[xm1_half];
        odd_rd0_reg  <= odd_bank[odd_addr];
        odd_rd1_reg  <= odd_bank[xm1_half];
        // A write to the same column at this edge is passed straight through.
        if (up_wr_en && (up_wr_x == rd_x))
        begin
            upper_rd_reg <= up_wr_data;
        end
        else
        begin
            upper_rd_reg <= upper_line[rd_x];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mid_wr_en && !mid_wr_x[0])
        begin
            even_bank[mid_wr_x[X_W-1:1]] <= mid_wr_data;
        end
        if (mid_wr_en && mid_wr_x[0])
        begin
            odd_bank[mid_wr_x[X_W-1:1]] <= mid_wr_data;
        end
        if (up_wr_en)
        begin
            upper_line[up_wr_x] <= up_wr_data;
        end
    end

    assign mid_data   = par_reg ? odd_rd0_reg : even_rd0_reg;
    assign right_data = par_reg ? even_rd0_reg : odd_rd0_reg;
    assign left_data  = par_reg ? even_rd1_reg : odd_rd1_reg;
    assign upper_data = upper_rd_reg;

endmodule

@@ hdl/s2x_checker.sv @@
// Port-level checks for the Scale2x palette upscaler, bound to the top level.
// Depends on s2x_pkg and on the port names of scale2x_palette_upscaler.
module s2x_checker import s2x_pkg::*; #(
    parameter int LINE_PIXELS = S2X_LINE_PIXELS
) (
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                result_valid,
    input logic                result_ready,
    input logic                block_valid,
    input logic                frame_done,
    input logic [COORD_W-1:0]  source_column,
    input logic [COLOUR_W-1:0] top_right,
    input logic [COLOUR_W-1:0] bottom_left,
    input logic [COLOUR_W-1:0] bottom_right
);

    // A word on offer stays on offer until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result word withdrawn before it was taken");

    // A passthrough word carries only its top left colour.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !block_valid |->
            (top_right == '0) && (bottom_left == '0) && (bottom_right == '0))
        else $error("passthrough word with non-zero block colours");

    // A result appearing in an empty queue must come from an accepted input word.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(item_valid && item_ready, 3))
        else $error("result appeared without a matching input word");

    // A scaled frame ends on the last column of the line.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && block_valid && frame_done |->
            (source_column == COORD_W'(LINE_PIXELS - 1)))
        else $error("scaled frame ended away from the last column");

endmodule

bind scale2x_palette_upscaler s2x_checker #(
    .LINE_PIXELS (LINE_PIXELS)
) u_s2x_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (items.valid),
    .item_ready    (items.ready),
    .result_valid  (results.valid),
    .result_ready  (results.ready),
    .block_valid   (results.block_valid),
    .frame_done    (results.frame_done),
    .source_column (results.source_column),
    .top_right     (results.top_right),
    .bottom_left   (results.bottom_left),
    .bottom_right  (results.bottom_right)
);
